@@ src/vxlan_pkg.sv @@
package vxlan_pkg;

    localparam int TUNNEL_ENTRIES = 16;
    localparam int IDX_W = (TUNNEL_ENTRIES > 1) ? $clog2(TUNNEL_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TUNNEL_ENTRIES + 1);
    localparam int HDR_LEN = 50;
    localparam logic [15:0] MAX_INNER = 16'd65485;
    localparam logic [15:0] UDP_PORT = 16'd4789;

    localparam logic [1:0] FUNC_ADD = 2'd0;
    localparam logic [1:0] FUNC_ENCAP = 2'd1;
    localparam logic [1:0] FUNC_DECAP = 2'd2;
    localparam logic [1:0] FUNC_NONE = 2'd3;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_FULL = 3'd1;
    localparam logic [2:0] ST_UNKNOWN = 3'd2;
    localparam logic [2:0] ST_TOO_LARGE = 3'd3;
    localparam logic [2:0] ST_TOO_SHORT = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_HEADER,
        S_BODY,
        S_OUT
    } state_t;

    // header byte at position pos, given the stored entry fields
    function automatic logic [7:0] hdr_byte(
        input logic [5:0] pos,
        input logic [15:0] len,
        input logic [31:0] src,
        input logic [31:0] dst,
        input logic [23:0] vni
    );
        logic [15:0] ip_len;
        logic [15:0] udp_len;
        logic [7:0] b;
        ip_len = len + 16'd36;
        udp_len = len + 16'd16;
        b = 8'h00;
        case (pos)
            6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5: b = 8'hFF;
            6'd12: b = 8'h08;
            6'd14: b = 8'h45;
            6'd16: b = ip_len[15:8];
            6'd17: b = ip_len[7:0];
            6'd22: b = 8'd64;
            6'd23: b = 8'd17;
            6'd26: b = src[31:24];
            6'd27: b = src[23:16];
            6'd28: b = src[15:8];
            6'd29: b = src[7:0];
            6'd30: b = dst[31:24];
            6'd31: b = dst[23:16];
            6'd32: b = dst[15:8];
            6'd33: b = dst[7:0];
            6'd34, 6'd36: b = UDP_PORT[15:8];
            6'd35, 6'd37: b = UDP_PORT[7:0];
            6'd38: b = udp_len[15:8];
            6'd39: b = udp_len[7:0];
            6'd42: b = 8'h08;
            6'd46: b = vni[23:16];
            6'd47: b = vni[15:8];
            6'd48: b = vni[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

@@ src/vxlan_tunnel_encap_decap.sv @@
// channel  | valid      | ready      | payload
// input    | s_valid    | s_ready    | s_func s_tunnel_key s_source_ip s_dest_ip s_net_id
//          |            |            | s_packet_length s_data_in s_last_in
// result   | m_valid    | m_ready    | m_data_out m_byte_valid m_last_out m_status
//          |            |            | m_encap_total m_decap_total
// an add loads its status beat into the result register at accept; the next beat can follow.
// a passing byte is accepted in S_IDLE, then loaded into the result register in S_BODY.
// an encap first byte scans the table one entry a cycle through the single read port,
// re-reads the hit in S_OUT, then emits 50 header beats.
// reset (aresetn low, synchronous) empties the table count and clears counters.
// m_ready low holds a valid result beat and stalls input accept, header and body beats.
module vxlan_tunnel_encap_decap (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [31:0] s_tunnel_key,
    input  logic [31:0] s_source_ip,
    input  logic [31:0] s_dest_ip,
    input  logic [23:0] s_net_id,
    input  logic [15:0] s_packet_length,
    input  logic [7:0]  s_data_in,
    input  logic        s_last_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_data_out,
    output logic        m_byte_valid,
    output logic        m_last_out,
    output logic [2:0]  m_status,
    output logic [63:0] m_encap_total,
    output logic [63:0] m_decap_total
);

    localparam int IW = vxlan_pkg::IDX_W;
    localparam int CW = vxlan_pkg::CNT_W;
    localparam int N = vxlan_pkg::TUNNEL_ENTRIES;

    // tunnel table, one wide word per entry
    logic [119:0] mem [N];
    logic [119:0] rd_reg;
    logic [IW-1:0] rd_addr;
    logic          wr_en;

    vxlan_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic          in_pkt_reg, in_pkt_next;
    logic          mode_enc_reg, mode_enc_next;
    logic [15:0]   pos_reg, pos_next;
    logic [2:0]    pst_reg, pst_next;
    logic [63:0]   enc_reg, enc_next;
    logic [63:0]   dec_reg, dec_next;
    logic [5:0]    hpos_reg, hpos_next;
    logic          hdr_beat_reg, hdr_beat_next;

    // captured input beat
    logic [31:0] key_reg;
    logic [15:0] len_reg;
    logic [7:0]  dat_reg;
    logic        last_reg;

    // result register
    logic        mv_reg, mv_next;
    logic [7:0]  md_reg, md_next;
    logic        mb_reg, mb_next;
    logic        ml_reg, ml_next;
    logic [2:0]  ms_reg, ms_next;

    logic out_free;
    logic accept;
    logic [IW-1:0] scan_idx;

    assign out_free = !mv_reg || m_ready;
    assign accept = s_valid && s_ready;
    assign scan_idx = scan_reg[IW-1:0];

    // table write on add, read at the scan index
    assign wr_en = accept && (s_func == vxlan_pkg::FUNC_ADD) && (count_reg < CW'(N));
    assign rd_addr = (state_reg == vxlan_pkg::S_SEARCH) ? scan_idx : scan_idx;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[count_reg[IW-1:0]] <= {s_tunnel_key, s_source_ip, s_dest_ip, s_net_id};
        end
        rd_reg <= mem[rd_addr];
    end

    // capture payload of accepted beat
    always_ff @(posedge aclk) begin
        if (accept) begin
            key_reg <= s_tunnel_key;
            dat_reg <= s_data_in;
            last_reg <= s_last_in;
            if (!in_pkt_reg) begin
                len_reg <= s_packet_length;
            end
        end
    end

    always_ff @(posedge aclk) begin
        md_reg <= md_next;
        mb_reg <= mb_next;
        ml_reg <= ml_next;
        ms_reg <= ms_next;
        if (!aresetn) begin
            state_reg <= vxlan_pkg::S_IDLE;
            count_reg <= '0;
            scan_reg <= '0;
            in_pkt_reg <= 1'b0;
            mode_enc_reg <= 1'b1;
            pos_reg <= '0;
            pst_reg <= vxlan_pkg::ST_OK;
            enc_reg <= '0;
            dec_reg <= '0;
            hpos_reg <= '0;
            hdr_beat_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            scan_reg <= scan_next;
            in_pkt_reg <= in_pkt_next;
            mode_enc_reg <= mode_enc_next;
            pos_reg <= pos_next;
            pst_reg <= pst_next;
            enc_reg <= enc_next;
            dec_reg <= dec_next;
            hpos_reg <= hpos_next;
            hdr_beat_reg <= hdr_beat_next;
            mv_reg <= mv_next;
        end
    end

    // control: accept, scan, header emission, body byte
    always_comb begin
        logic [119:0] e;
        e = rd_reg;
        state_next = state_reg;
        count_next = count_reg;
        scan_next = scan_reg;
        in_pkt_next = in_pkt_reg;
        mode_enc_next = mode_enc_reg;
        pos_next = pos_reg;
        pst_next = pst_reg;
        enc_next = enc_reg;
        dec_next = dec_reg;
        hpos_next = hpos_reg;
        hdr_beat_next = hdr_beat_reg;
        mv_next = mv_reg && !m_ready;
        md_next = md_reg;
        mb_next = mb_reg;
        ml_next = ml_reg;
        ms_next = ms_reg;
        s_ready = 1'b0;

        case (state_reg)
            vxlan_pkg::S_IDLE: begin
                s_ready = out_free;
                if (accept) begin
                    case (s_func)
                        vxlan_pkg::FUNC_ADD: begin
                            mv_next = 1'b1;
                            md_next = 8'h00;
                            mb_next = 1'b0;
                            ml_next = 1'b1;
                            hdr_beat_next = 1'b0;
                            if (count_reg < CW'(N)) begin
                                count_next = count_reg + CW'(1);
                                ms_next = vxlan_pkg::ST_OK;
                            end else begin
                                ms_next = vxlan_pkg::ST_FULL;
                            end
                        end
                        vxlan_pkg::FUNC_ENCAP, vxlan_pkg::FUNC_DECAP: begin
                            if (!in_pkt_reg) begin
                                in_pkt_next = 1'b1;
                                pos_next = '0;
                                pst_next = vxlan_pkg::ST_OK;
                                mode_enc_next = (s_func == vxlan_pkg::FUNC_ENCAP);
                                if (s_func == vxlan_pkg::FUNC_ENCAP) begin
                                    scan_next = '0;
                                    state_next = (count_reg == '0) ? vxlan_pkg::S_BODY
                                                                   : vxlan_pkg::S_SEARCH;
                                    if (count_reg == '0) begin
                                        pst_next = vxlan_pkg::ST_UNKNOWN;
                                    end
                                end else begin
                                    if (s_packet_length < 16'(vxlan_pkg::HDR_LEN)) begin
                                        pst_next = vxlan_pkg::ST_TOO_SHORT;
                                    end
                                    state_next = vxlan_pkg::S_BODY;
                                end
                            end else begin
                                state_next = vxlan_pkg::S_BODY;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // one entry read per cycle; rd_reg holds entry scan_reg-1
            vxlan_pkg::S_SEARCH: begin
                if (scan_reg != '0 && e[119:88] == key_reg) begin
                    scan_next = scan_reg - CW'(1);
                    if (len_reg > vxlan_pkg::MAX_INNER) begin
                        pst_next = vxlan_pkg::ST_TOO_LARGE;
                        state_next = vxlan_pkg::S_BODY;
                    end else begin
                        hpos_next = '0;
                        state_next = vxlan_pkg::S_OUT;
                    end
                end else if (scan_reg == count_reg) begin
                    pst_next = vxlan_pkg::ST_UNKNOWN;
                    state_next = vxlan_pkg::S_BODY;
                end else begin
                    scan_next = scan_reg + CW'(1);
                end
            end
            // re-read the found entry so rd_reg holds it
            vxlan_pkg::S_OUT: begin
                state_next = vxlan_pkg::S_HEADER;
            end
            vxlan_pkg::S_HEADER: begin
                if (out_free) begin
                    mv_next = 1'b1;
                    md_next = vxlan_pkg::hdr_byte(hpos_reg, len_reg, e[87:56], e[55:24],
                                                  e[23:0]);
                    mb_next = 1'b1;
                    ml_next = 1'b0;
                    ms_next = vxlan_pkg::ST_OK;
                    hdr_beat_next = 1'b1;
                    hpos_next = hpos_reg + 6'd1;
                    if (hpos_reg == 6'(vxlan_pkg::HDR_LEN - 1)) begin
                        state_next = vxlan_pkg::S_BODY;
                    end
                end
            end
            vxlan_pkg::S_BODY: begin
                if (out_free) begin
                    state_next = vxlan_pkg::S_IDLE;
                    md_next = 8'h00;
                    mb_next = 1'b0;
                    ml_next = 1'b1;
                    ms_next = pst_reg;
                    hdr_beat_next = 1'b0;
                    if (pst_reg != vxlan_pkg::ST_OK) begin
                        mv_next = last_reg;
                    end else if (mode_enc_reg) begin
                        mv_next = 1'b1;
                        md_next = dat_reg;
                        mb_next = 1'b1;
                        ml_next = last_reg;
                        if (last_reg) begin
                            enc_next = enc_reg + 64'd1;
                        end
                    end else if (pos_reg < 16'(vxlan_pkg::HDR_LEN)) begin
                        mv_next = last_reg;
                        if (pos_reg == 16'(vxlan_pkg::HDR_LEN - 1)) begin
                            ms_next = vxlan_pkg::ST_OK;
                            if (last_reg) begin
                                dec_next = dec_reg + 64'd1;
                            end
                        end else begin
                            ms_next = vxlan_pkg::ST_TOO_SHORT;
                        end
                    end else begin
                        mv_next = 1'b1;
                        md_next = dat_reg;
                        mb_next = 1'b1;
                        ml_next = last_reg;
                        if (last_reg) begin
                            dec_next = dec_reg + 64'd1;
                        end
                    end
                    if (pos_reg != 16'hFFFF) begin
                        pos_next = pos_reg + 16'd1;
                    end
                    if (last_reg) begin
                        in_pkt_next = 1'b0;
                    end
                end
            end
            default: begin
                state_next = vxlan_pkg::S_IDLE;
            end
        endcase
    end

    assign m_valid = mv_reg;
    assign m_data_out = md_reg;
    assign m_byte_valid = mb_reg;
    assign m_last_out = ml_reg;
    assign m_status = ms_reg;
    // header beats of a one-byte packet already show the count that its byte adds
    assign m_encap_total = enc_reg + {63'd0, hdr_beat_reg && last_reg};
    assign m_decap_total = dec_reg;

endmodule

@@ src/vxlan_checker.sv @@
module vxlan_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_data_out,
    input logic        m_byte_valid,
    input logic        m_last_out,
    input logic [2:0]  m_status
);

    // offered input beat stays until taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("input beat withdrawn");

    // stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data_out) && $stable(m_status))
        else $error("result beat changed under stall");

    // failure status only on a status-only final beat
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != 3'd0 |-> !m_byte_valid && m_last_out)
        else $error("bad status beat");

    // status-only beats carry zero data
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_byte_valid |-> m_data_out == 8'h00)
        else $error("status beat with data");

    // status codes stay in range
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= 3'd4)
        else $error("status out of range");

endmodule

bind vxlan_tunnel_encap_decap vxlan_checker u_vxlan_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data_out(m_data_out),
    .m_byte_valid(m_byte_valid), .m_last_out(m_last_out), .m_status(m_status)
);

@@ sim/vxlan_tunnel_encap_decap_test.sv @@
`timescale 1ns / 100ps

module vxlan_tunnel_encap_decap_test;

    typedef struct {
        logic [1:0]  func;
        logic [31:0] key;
        logic [31:0] src;
        logic [31:0] dst;
        logic [23:0] vni;
        logic [15:0] len;
        logic [7:0]  data;
        logic        last;
    } in_beat_t;

    typedef struct {
        logic [7:0]  data;
        logic        bvalid;
        logic        last;
        logic [2:0]  status;
        logic [63:0] enc;
        logic [63:0] dec;
    } out_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_func = vxlan_pkg::FUNC_NONE;
    logic [31:0] s_tunnel_key = '0;
    logic [31:0] s_source_ip = '0;
    logic [31:0] s_dest_ip = '0;
    logic [23:0] s_net_id = '0;
    logic [15:0] s_packet_length = '0;
    logic [7:0]  s_data_in = '0;
    logic        s_last_in = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_data_out;
    logic        m_byte_valid;
    logic        m_last_out;
    logic [2:0]  m_status;
    logic [63:0] m_encap_total;
    logic [63:0] m_decap_total;

    vxlan_tunnel_encap_decap DUT (.*);

    always #6 aclk = ~aclk;

    // stimulus side
    in_beat_t  pending_beats[$];
    out_beat_t expected_beats[$];
    in_beat_t  cur_beat;
    int        stim_items = 0;
    int        gen_entries = 0;
    logic [31:0] gen_keys[$];

    // predictor copy of the tunnel table and packet state
    logic [31:0] tbl_key[vxlan_pkg::TUNNEL_ENTRIES];
    logic [31:0] tbl_src[vxlan_pkg::TUNNEL_ENTRIES];
    logic [31:0] tbl_dst[vxlan_pkg::TUNNEL_ENTRIES];
    logic [23:0] tbl_vni[vxlan_pkg::TUNNEL_ENTRIES];
    int          tbl_count = 0;
    bit          pkt_open = 0;
    logic [1:0]  pkt_mode = vxlan_pkg::FUNC_ENCAP;
    int          pkt_pos = 0;
    logic [2:0]  pkt_status = vxlan_pkg::ST_OK;
    logic [63:0] encap_count = '0;
    logic [63:0] decap_count = '0;

    // bookkeeping
    int accepted = 0;
    int results = 0;
    int mismatches = 0;
    int tx_gap = 0;
    int rx_gap = 0;
    int hold_cycles = 0;
    bit hold_done = 0;

    function automatic int pick_gap(input int phase_count);
        int r;
        if ((phase_count / 40) % 3 == 1) return 0;
        r = $urandom_range(0, 9);
        if (r < 6) return 0;
        if (r < 9) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // append a result to a local list for this input beat
    function automatic void add_out(ref out_beat_t q[$], input logic [7:0] d,
                                    input logic bv, input logic l, input logic [2:0] st);
        out_beat_t o;
        o.data = d; o.bvalid = bv; o.last = l; o.status = st; o.enc = '0; o.dec = '0;
        q.push_back(o);
    endfunction

    // work out the result beats caused by one accepted input beat
    task automatic predict_beats(input in_beat_t b);
        out_beat_t   outs[$];
        logic [7:0]  hdr[50];
        logic [15:0] ip_len;
        logic [15:0] udp_len;
        int          hit;
        if (b.func == vxlan_pkg::FUNC_NONE) return;
        if (b.func == vxlan_pkg::FUNC_ADD) begin
            if (tbl_count >= vxlan_pkg::TUNNEL_ENTRIES) begin
                add_out(outs, 8'h00, 1'b0, 1'b1, vxlan_pkg::ST_FULL);
            end else begin
                tbl_key[tbl_count] = b.key;
                tbl_src[tbl_count] = b.src;
                tbl_dst[tbl_count] = b.dst;
                tbl_vni[tbl_count] = b.vni;
                tbl_count++;
                add_out(outs, 8'h00, 1'b0, 1'b1, vxlan_pkg::ST_OK);
            end
        end else begin
            // first byte of a packet samples mode, key and length
            if (!pkt_open) begin
                pkt_open = 1;
                pkt_mode = b.func;
                pkt_pos = 0;
                pkt_status = vxlan_pkg::ST_OK;
                if (pkt_mode == vxlan_pkg::FUNC_ENCAP) begin
                    hit = -1;
                    for (int i = 0; i < tbl_count; i++)
                        if (hit < 0 && tbl_key[i] == b.key) hit = i;
                    if (hit < 0) pkt_status = vxlan_pkg::ST_UNKNOWN;
                    else if (b.len > vxlan_pkg::MAX_INNER) pkt_status = vxlan_pkg::ST_TOO_LARGE;
                    else begin
                        ip_len = b.len + 16'd36;
                        udp_len = b.len + 16'd16;
                        foreach (hdr[i]) hdr[i] = 8'h00;
                        for (int i = 0; i < 6; i++) hdr[i] = 8'hFF;
                        hdr[12] = 8'h08;
                        hdr[14] = 8'h45;
                        {hdr[16], hdr[17]} = ip_len;
                        hdr[22] = 8'd64;
                        hdr[23] = 8'd17;
                        {hdr[26], hdr[27], hdr[28], hdr[29]} = tbl_src[hit];
                        {hdr[30], hdr[31], hdr[32], hdr[33]} = tbl_dst[hit];
                        {hdr[34], hdr[35]} = vxlan_pkg::UDP_PORT;
                        {hdr[36], hdr[37]} = vxlan_pkg::UDP_PORT;
                        {hdr[38], hdr[39]} = udp_len;
                        hdr[42] = 8'h08;
                        {hdr[46], hdr[47], hdr[48]} = tbl_vni[hit];
                        foreach (hdr[i]) add_out(outs, hdr[i], 1'b1, 1'b0, vxlan_pkg::ST_OK);
                    end
                end else if (b.len < vxlan_pkg::HDR_LEN) begin
                    pkt_status = vxlan_pkg::ST_TOO_SHORT;
                end
            end
            // byte handling in the mode sampled at packet start
            if (pkt_status != vxlan_pkg::ST_OK) begin
                if (b.last) add_out(outs, 8'h00, 1'b0, 1'b1, pkt_status);
            end else if (pkt_mode == vxlan_pkg::FUNC_ENCAP) begin
                if (b.last) encap_count++;
                add_out(outs, b.data, 1'b1, b.last, vxlan_pkg::ST_OK);
            end else if (pkt_pos < vxlan_pkg::HDR_LEN) begin
                if (b.last) begin
                    if (pkt_pos == vxlan_pkg::HDR_LEN - 1) begin
                        decap_count++;
                        add_out(outs, 8'h00, 1'b0, 1'b1, vxlan_pkg::ST_OK);
                    end else begin
                        add_out(outs, 8'h00, 1'b0, 1'b1, vxlan_pkg::ST_TOO_SHORT);
                    end
                end
            end else begin
                if (b.last) decap_count++;
                add_out(outs, b.data, 1'b1, b.last, vxlan_pkg::ST_OK);
            end
            if (pkt_pos < 65535) pkt_pos++;
            if (b.last) pkt_open = 0;
        end
        foreach (outs[i]) begin
            outs[i].enc = encap_count;
            outs[i].dec = decap_count;
            expected_beats.push_back(outs[i]);
        end
    endtask

    // queue builders
    task automatic queue_beat(input logic [1:0] f, input logic [31:0] k, input logic [15:0] l,
                              input logic [7:0] d, input logic lst);
        in_beat_t b;
        b.func = f; b.key = k; b.len = l; b.data = d; b.last = lst;
        b.src = $urandom; b.dst = $urandom; b.vni = $urandom;
        pending_beats.push_back(b);
        if (f != vxlan_pkg::FUNC_NONE) stim_items++;
    endtask

    task automatic queue_add(input logic [31:0] k, input logic [31:0] sip,
                             input logic [31:0] dip, input logic [23:0] v);
        in_beat_t b;
        b.func = vxlan_pkg::FUNC_ADD; b.key = k; b.src = sip; b.dst = dip; b.vni = v;
        b.len = $urandom; b.data = $urandom; b.last = $urandom;
        pending_beats.push_back(b);
        stim_items++;
        if (gen_entries < vxlan_pkg::TUNNEL_ENTRIES) begin
            gen_keys.push_back(k);
            gen_entries++;
        end
    endtask

    // one packet; with mix set, odd beats land inside it
    task automatic queue_packet(input logic [1:0] f, input logic [31:0] k,
                                input logic [15:0] l, input int nb, input bit mix);
        logic [1:0] bf;
        for (int i = 0; i < nb; i++) begin
            bf = f;
            if (mix && i > 0) begin
                case ($urandom_range(0, 7))
                    0: queue_add($urandom, $urandom, $urandom, $urandom);
                    1: queue_beat(vxlan_pkg::FUNC_NONE, $urandom, $urandom, $urandom,
                                  $urandom);
                    2: bf = (f == vxlan_pkg::FUNC_ENCAP) ? vxlan_pkg::FUNC_DECAP
                                                         : vxlan_pkg::FUNC_ENCAP;
                    default: ;
                endcase
            end
            if (i == 0) queue_beat(bf, k, l, $urandom, nb == 1);
            else queue_beat(bf, $urandom, $urandom, $urandom, i == nb - 1);
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_beats(cur_beat);
                accepted++;
            end
            if (!s_valid || s_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_valid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    cur_beat = pending_beats.pop_front();
                    s_func <= cur_beat.func;
                    s_tunnel_key <= cur_beat.key;
                    s_source_ip <= cur_beat.src;
                    s_dest_ip <= cur_beat.dst;
                    s_net_id <= cur_beat.vni;
                    s_packet_length <= cur_beat.len;
                    s_data_in <= cur_beat.data;
                    s_last_in <= cur_beat.last;
                    s_valid <= 1'b1;
                    tx_gap = pick_gap(accepted);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and checker
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results++;
                if (expected_beats.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: data %h bv %b last %b status %0d",
                                 m_data_out, m_byte_valid, m_last_out, m_status);
                end else begin
                    out_beat_t e;
                    e = expected_beats.pop_front();
                    if (m_data_out !== e.data || m_byte_valid !== e.bvalid ||
                        m_last_out !== e.last || m_status !== e.status ||
                        m_encap_total !== e.enc || m_decap_total !== e.dec) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch at result %0d:", results);
                            $display("  exp data %h bv %b last %b st %0d enc %0d dec %0d",
                                     e.data, e.bvalid, e.last, e.status, e.enc, e.dec);
                            $display("  got data %h bv %b last %b st %0d enc %0d dec %0d",
                                     m_data_out, m_byte_valid, m_last_out, m_status,
                                     m_encap_total, m_decap_total);
                        end
                    end
                end
            end
            // one long hold-off so the block backs up into its input
            if (!hold_done && results >= 150) begin
                hold_cycles++;
                m_ready <= 1'b0;
                if (hold_cycles >= 400) hold_done = 1;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                rx_gap = pick_gap(results + 20);
            end
        end
    end

    // run limit
    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // stimulus and end of run
    initial begin
        int r;
        int kidx;
        // directed: empty table lookup, field extremes, every status but full
        queue_packet(vxlan_pkg::FUNC_ENCAP, 32'h0, 16'd4, 2, 0);
        queue_add(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 24'hFF_FFFF);
        queue_add(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 24'h00_0000);
        queue_beat(vxlan_pkg::FUNC_ENCAP, 32'hFFFF_FFFF, 16'd0, 8'hFF, 1'b1);
        queue_beat(vxlan_pkg::FUNC_ENCAP, 32'h0, 16'd65485, 8'h00, 1'b1);
        queue_packet(vxlan_pkg::FUNC_ENCAP, 32'h0, 16'd65486, 2, 0);
        queue_packet(vxlan_pkg::FUNC_ENCAP, 32'hFFFF_FFFF, 16'hFFFF, 1, 0);
        queue_beat(vxlan_pkg::FUNC_NONE, 32'h0, 16'h0, 8'h00, 1'b1);
        queue_packet(vxlan_pkg::FUNC_DECAP, 32'h0, 16'd49, 3, 0);
        queue_packet(vxlan_pkg::FUNC_DECAP, 32'h0, 16'd50, 50, 0);
        queue_packet(vxlan_pkg::FUNC_DECAP, 32'h0, 16'd60, 30, 0);
        queue_packet(vxlan_pkg::FUNC_DECAP, 32'h0, 16'hFFFF, 52, 0);
        queue_add(32'h0000_0000, 32'h0A0B_0C0D, 32'h1122_3344, 24'h12_3456);
        queue_packet(vxlan_pkg::FUNC_ENCAP, 32'h0, 16'd3, 6, 1);

        // random: mostly well-formed packets against known tunnels
        while (stim_items < 280) begin
            r = $urandom_range(0, 99);
            kidx = $urandom_range(0, gen_keys.size() - 1);
            if (r < 12) begin
                if ($urandom_range(0, 3) == 0)
                    queue_add(gen_keys[kidx], $urandom, $urandom, $urandom);
                else
                    queue_add($urandom, $urandom, $urandom, $urandom);
            end else if (r < 15) begin
                queue_beat(vxlan_pkg::FUNC_NONE, $urandom, $urandom, $urandom, $urandom);
            end else if (r < 60) begin
                queue_packet(vxlan_pkg::FUNC_ENCAP, gen_keys[kidx],
                             ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(0, 20)),
                             $urandom_range(1, 8), $urandom_range(0, 3) == 0);
            end else if (r < 68) begin
                queue_packet(vxlan_pkg::FUNC_ENCAP, $urandom, $urandom,
                             $urandom_range(1, 4), 0);
            end else if (r < 88) begin
                queue_packet(vxlan_pkg::FUNC_DECAP, $urandom, $urandom_range(50, 70),
                             $urandom_range(50, 56), $urandom_range(0, 3) == 0);
            end else begin
                queue_packet(vxlan_pkg::FUNC_DECAP, $urandom, $urandom_range(0, 60),
                             $urandom_range(1, 49), 0);
            end
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_beats.size() > 0 || s_valid) @(posedge aclk);
        while (expected_beats.size() > 0) @(posedge aclk);
        repeat (200) @(posedge aclk);

        $display("run: %0d input beats accepted, %0d result beats checked, %0d tunnels",
                 accepted, results, tbl_count);
        $display("     %0d packets encapsulated, %0d decapsulated", encap_count, decap_count);
        if (mismatches == 0 && expected_beats.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d beats missing", mismatches, expected_beats.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/vxlan_pkg.sv
src/vxlan_tunnel_encap_decap.sv
src/vxlan_checker.sv
sim/vxlan_tunnel_encap_decap_test.sv
